/* design/abm_pkg.sv */
// shared types and constants for the allocation bitmap first-free block
`timescale 1ns / 1ps

package abm_pkg;

  // bitmap geometry
  localparam int TOTAL_BITS = 1024;
  localparam int WORD_BITS  = 32;
  localparam int WORD_COUNT = (TOTAL_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(WORD_COUNT);
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int IDX_W      = 10;
  localparam int LEN_W      = 11;
  localparam int MODE_W     = 3;
  localparam int STATUS_W   = 2;

  // request modes
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  // configuration register byte addresses
  localparam logic [2:0] ADDR_BITS_IN_USE = 3'd0;

  // reset value of the length register
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(TOTAL_BITS);

  // answer of the word scan unit
  typedef struct packed {
    logic             hit;
    logic [OFF_W-1:0] offset;
  } scan_res_t;

endpackage

/* design/abm_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module abm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/abm_scan.sv */
// word scan unit: first free bit of one word from the msb, limited by the length
`timescale 1ns / 1ps

module abm_scan (
  input  logic [abm_pkg::WORD_BITS-1:0] word,
  input  logic [abm_pkg::WORD_AW-1:0]   word_idx,
  input  logic [abm_pkg::LEN_W-1:0]     len,
  output abm_pkg::scan_res_t            res
);
  import abm_pkg::*;

  logic [LEN_W:0]       base;
  logic [LEN_W:0]       rem;
  logic [OFF_W-1:0]     count;
  logic                 full;
  logic [WORD_BITS-1:0] live_mask;
  logic [WORD_BITS-1:0] free_bits;

  // bits of this word that lie below the length
  always_comb begin
    base      = (LEN_W+1)'({word_idx, {OFF_W{1'b0}}});
    rem       = (LEN_W+1)'(len) - base;
    full      = ((LEN_W+1)'(len) >= base + (LEN_W+1)'(WORD_BITS));
    count     = (len > base[LEN_W-1:0] && !base[LEN_W]) ? rem[OFF_W-1:0] : '0;
    live_mask = full ? '1 : ~({WORD_BITS{1'b1}} >> count);
    free_bits = ~word & live_mask;
  end

  // priority encoder, highest set bit gives the lowest index
  always_comb begin
    res.hit    = |free_bits;
    res.offset = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_bits[i]) begin
        res.offset = OFF_W'(WORD_BITS - 1 - i);
      end
    end
  end

endmodule

/* design/allocation_bitmap_first_free_unit.sv */
// top level of the allocation bitmap with first-free search
//
//   channel  dir  handshake                  word
//   apb      in   psel penable pwrite pready bits_in_use at address 0
//   s        in   s_tvalid s_tready          s_tdata: mode, index
//   m        out  m_tvalid m_tready          m_tdata: status, bit_value, found_index
//
// one word at a time: set, clear, toggle and read pass from accept to result valid
// through word read, modify and write, then output load; an out of range request
// goes straight to output load. find first free reads one bitmap word per cycle
// through the scan unit up to the last word of the length. reset clears the bitmap
// at once through one valid flag per word; no clearing pass. s_tready is low while
// an item is in work or its result waits for the output register.
`timescale 1ns / 1ps

module allocation_bitmap_first_free_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // mode[2:0], index[12:3], zero[15:13]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // status[1:0], bit_value[2], found_index[12:3], zero[15:13]
);
  import abm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BIT,
    S_FIND,
    S_OUT
  } state_t;

  state_t state;

  logic [LEN_W-1:0]     bits_in_use;
  logic [LEN_W-1:0]     len;
  logic [WORD_AW-1:0]   last_word;
  logic [WORD_COUNT-1:0] wvalid;
  logic                 rd_valid;

  logic [MODE_W-1:0]    item_mode;
  logic [IDX_W-1:0]     item_index;
  logic [MODE_W-1:0]    mode_r;
  logic [IDX_W-1:0]     idx_r;
  logic [WORD_AW-1:0]   chk_word;

  logic [STATUS_W-1:0]  res_status;
  logic                 res_bit;
  logic [IDX_W-1:0]     res_found;

  logic [WORD_AW-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_q;
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 cfg_write;
  scan_res_t            scan;

  // request fields and effective length
  assign item_mode  = s_tdata[2:0];
  assign item_index = s_tdata[12:3];
  assign len        = (bits_in_use > LEN_W'(TOTAL_BITS)) ? LEN_W'(TOTAL_BITS) : bits_in_use;
  assign last_word  = WORD_AW'((len - LEN_W'(1)) >> OFF_W);

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == ADDR_BITS_IN_USE[2]) ? 32'(bits_in_use) : 32'd0;

  assign s_tready = (state == S_IDLE);

  // read address: next word of a scan, else the word the waiting request names
  always_comb begin
    if (state == S_FIND) begin
      ram_raddr = chk_word + WORD_AW'(1);
    end else if (item_mode == MODE_FIND) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = item_index[IDX_W-1:OFF_W];
    end
  end

  // word never written reads as free
  assign word_q = ram_rdata & {WORD_BITS{rd_valid}};

  // read-modify-write of one bit
  assign bit_mask = {1'b1, {(WORD_BITS-1){1'b0}}} >> idx_r[OFF_W-1:0];

  always_comb begin
    unique case (mode_r)
      MODE_SET:    ram_wdata = word_q | bit_mask;
      MODE_CLEAR:  ram_wdata = word_q & ~bit_mask;
      MODE_TOGGLE: ram_wdata = word_q ^ bit_mask;
      default:     ram_wdata = word_q;
    endcase
  end

  assign ram_we = (state == S_BIT) && (mode_r != MODE_READ);

  abm_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r[IDX_W-1:OFF_W]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  abm_scan u_scan (
    .word     (word_q),
    .word_idx (chk_word),
    .len      (len),
    .res      (scan)
  );

  // valid flag read alongside the ram data
  always_ff @(posedge clk) begin
    rd_valid <= wvalid[ram_raddr];
  end

  // sequencer, configuration register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bits_in_use <= LEN_RESET;
      wvalid      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == ADDR_BITS_IN_USE[2]) begin
        bits_in_use <= pwdata[LEN_W-1:0];
      end
      if (ram_we) begin
        wvalid[idx_r[IDX_W-1:OFF_W]] <= 1'b1;
      end
      // result taken and no new one loading behind it
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            mode_r    <= item_mode;
            idx_r     <= item_index;
            chk_word  <= '0;
            res_bit   <= 1'b0;
            res_found <= '0;
            priority if (item_mode == MODE_FIND) begin
              if (len == '0) begin
                res_status <= ST_NONE;
                state      <= S_OUT;
              end else begin
                state <= S_FIND;
              end
            end else if (item_mode > MODE_FIND || LEN_W'(item_index) >= len) begin
              res_status <= ST_RANGE;
              state      <= S_OUT;
            end else begin
              state <= S_BIT;
            end
          end
        end
        S_BIT: begin
          res_status <= ST_OK;
          res_bit    <= (mode_r == MODE_READ) ? |(word_q & bit_mask) : 1'b0;
          state      <= S_OUT;
        end
        S_FIND: begin
          priority if (scan.hit) begin
            res_status <= ST_OK;
            res_found  <= {chk_word, scan.offset};
            state      <= S_OUT;
          end else if (chk_word == last_word) begin
            res_status <= ST_NONE;
            state      <= S_OUT;
          end else begin
            chk_word <= chk_word + WORD_AW'(1);
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, res_found, res_bit, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the bitmap is written only in the modify step
  a_write_in_bit: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_BIT)
    else $error("bitmap written outside the modify step");

  // a scan never runs past the last word of the length
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_FIND |-> chk_word <= last_word)
    else $error("scan past last word");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while busy");

  // no undefined status code leaves the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_RANGE ||
                  m_tdata[1:0] == ST_NONE))
    else $error("undefined status code");

  // a find that reports a hit names an index below the length
  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND && scan.hit) |=> LEN_W'(res_found) < len)
    else $error("found index beyond length");

endmodule

/* sim/tb_allocation_bitmap_first_free_unit.sv */
// testbench for the allocation bitmap with first-free search
`timescale 1ns / 1ps

import abm_pkg::*;

// one result word split into its fields
typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic                bit_value;
  logic [IDX_W-1:0]    found_index;
} alloc_answer_t;

// mirror of the bitmap plus the queue of answers still owed by the block
class alloc_map_model;
  logic [WORD_BITS-1:0] words [WORD_COUNT];
  logic [LEN_W-1:0]     bits_in_use;
  alloc_answer_t        owed_answers [$];
  alloc_answer_t        newest;
  int unsigned          failures;
  int unsigned          answered;
  int unsigned          free_hits;
  int unsigned          full_misses;
  int unsigned          range_rejects;

  function new();
    foreach (words[w]) words[w] = '0;
    bits_in_use   = LEN_RESET;
    newest        = '0;
    failures      = 0;
    answered      = 0;
    free_hits     = 0;
    full_misses   = 0;
    range_rejects = 0;
  endfunction

  // length clipped to the capacity of the store
  function int unsigned live_length();
    return (bits_in_use > TOTAL_BITS) ? TOTAL_BITS : int'(bits_in_use);
  endfunction

  function int unsigned owed();
    return owed_answers.size();
  endfunction

  function void flag(string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endfunction

  // apply one accepted request word and queue its answer
  function void note_request(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
    alloc_answer_t ans;
    int unsigned   eff;
    int unsigned   wi;
    int unsigned   bp;
    logic          hit;
    eff = live_length();
    ans = '0;
    hit = 1'b0;
    if (mode == MODE_FIND) begin
      // lowest zero bit below the length; padding past it never counts
      ans.status = ST_NONE;
      for (int unsigned i = 0; i < eff && !hit; i++) begin
        if (words[i / WORD_BITS][WORD_BITS - 1 - (i % WORD_BITS)] == 1'b0) begin
          hit             = 1'b1;
          ans.status      = ST_OK;
          ans.found_index = IDX_W'(i);
        end
      end
    end else if (mode > MODE_FIND || idx >= eff) begin
      ans.status = ST_RANGE;
    end else begin
      // msb-first numbering inside each word
      wi = idx / WORD_BITS;
      bp = WORD_BITS - 1 - (idx % WORD_BITS);
      case (mode)
        MODE_READ: begin
          ans.bit_value = words[wi][bp];
        end
        MODE_SET: begin
          words[wi][bp] = 1'b1;
        end
        MODE_CLEAR: begin
          words[wi][bp] = 1'b0;
        end
        default: begin
          words[wi][bp] = ~words[wi][bp];
        end
      endcase
    end
    owed_answers.push_back(ans);
    newest = ans;
  endfunction

  // compare one accepted result word against the oldest owed answer
  function void check_answer(logic [15:0] data);
    alloc_answer_t want;
    alloc_answer_t got;
    got.status      = data[1:0];
    got.bit_value   = data[2];
    got.found_index = data[12:3];
    if (owed_answers.size() == 0) begin
      flag($sformatf("result word with nothing owed: status %0d bit %0d index %0d",
                     got.status, got.bit_value, got.found_index));
      return;
    end
    want = owed_answers.pop_front();
    answered++;
    if (want.status == ST_OK && got.status == ST_OK && want.found_index != 0)
      free_hits++;
    if (want.status == ST_NONE) full_misses++;
    if (want.status == ST_RANGE) range_rejects++;
    if (got.status !== want.status || got.bit_value !== want.bit_value ||
        got.found_index !== want.found_index)
      flag($sformatf("answer %0d: exp status %0d bit %0d index %0d, got %0d %0d %0d",
                     answered, want.status, want.bit_value, want.found_index,
                     got.status, got.bit_value, got.found_index));
  endfunction
endclass

module tb_allocation_bitmap_first_free_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic [LEN_W-1:0]  LEN_MAX_CODE  = 11'd2047;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // mode[2:0], index[12:3], zero[15:13]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // status[1:0], bit_value[2], found_index[12:3], zero[15:13]

  alloc_map_model bitmap_model;
  bit             sender_gaps = 1'b1;
  bit             receiver_stalls = 1'b1;
  int unsigned    hold_off_cycles = 0;
  int unsigned    cycle_count = 0;
  int unsigned    words_sent = 0;
  int unsigned    lengths_tried = 0;

  allocation_bitmap_first_free_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL allocation_bitmap_first_free_unit");
    $finish;
  end

  // result side: random stall bursts and one long hold-off on request
  initial begin
    wait (rst == 1'b0);
    forever begin
      if (hold_off_cycles != 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        @(negedge clk);
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result word check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) bitmap_model.check_answer(m_tdata);
  end

  // lower valid for a burst of cycles
  task automatic pause_sender(input int unsigned n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // offer one request word and hold it until accepted
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, idx, mode};
    do @(posedge clk); while (!s_tready);
    bitmap_model.note_request(mode, idx);
    words_sent++;
    if (sender_gaps && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 9));
  endtask

  // one apb transfer to the length register
  task automatic apb_access(input logic wr, input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_BITS_IN_USE;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop offering and wait until every owed answer is back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bitmap_model.owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the length while idle and read it back
  task automatic program_length(input logic [LEN_W-1:0] len);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, 32'(len), rd);
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(len))
      bitmap_model.flag($sformatf("length readback exp %0d got %0d", len, rd));
    bitmap_model.bits_in_use = len;
    lengths_tried++;
  endtask

  // mostly a valid position, now and then any position
  function automatic logic [IDX_W-1:0] pick_index(input int unsigned eff);
    if (eff == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, 1023));
    return IDX_W'($urandom_range(0, eff - 1));
  endfunction

  // one random operation; allocation is a find followed by a set of the hit
  task automatic random_op();
    int unsigned r;
    int unsigned eff;
    eff = bitmap_model.live_length();
    r   = $urandom_range(0, 99);
    if (r < 40) begin
      send_request(MODE_FIND, IDX_W'($urandom_range(0, 1023)));
      if (bitmap_model.newest.status == ST_OK)
        send_request(MODE_SET, bitmap_model.newest.found_index);
    end else if (r < 60) begin
      send_request(MODE_CLEAR, pick_index(eff));
    end else if (r < 72) begin
      send_request(MODE_READ, pick_index(eff));
    end else if (r < 80) begin
      send_request(MODE_TOGGLE, pick_index(eff));
    end else if (r < 85) begin
      send_request(MODE_SET, pick_index(eff));
    end else if (r < 92) begin
      send_request(MODE_W'($urandom_range(MODE_READ, MODE_TOGGLE)),
                   IDX_W'($urandom_range(0, 1023)));
    end else begin
      send_request(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                   IDX_W'($urandom_range(0, 1023)));
    end
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] len, input int unsigned ops);
    program_length(len);
    repeat (ops) random_op();
  endtask

  // main sequence
  initial begin
    logic [31:0] rd;
    bitmap_model = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // length register comes out of reset at full capacity
    apb_access(1'b0, '0, rd);
    if (rd !== 32'(LEN_RESET))
      bitmap_model.flag($sformatf("length after reset exp %0d got %0d", LEN_RESET, rd));

    // directed: corners of the index, every mode, word boundaries
    send_request(MODE_FIND, '0);
    send_request(MODE_READ, '0);
    send_request(MODE_READ, 10'd1023);
    send_request(MODE_SET, '0);
    send_request(MODE_SET, 10'd1023);
    send_request(MODE_READ, 10'd1023);
    send_request(MODE_FIND, 10'd1023);
    send_request(MODE_TOGGLE, 10'd1);
    send_request(MODE_FIND, '0);
    send_request(MODE_TOGGLE, 10'd1);
    send_request(MODE_CLEAR, '0);
    send_request(MODE_SET, 10'd31);
    send_request(MODE_SET, 10'd32);
    send_request(MODE_READ, 10'd31);
    send_request(MODE_READ, 10'd32);
    send_request(MODE_SPARE_LO, 10'd3);
    send_request(3'd6, 10'd512);
    send_request(MODE_SPARE_HI, 10'd1023);

    // zero length: everything out of range, find comes back empty
    program_length('0);
    send_request(MODE_READ, '0);
    send_request(MODE_FIND, '0);
    send_request(MODE_SET, '0);

    // length past capacity clips to the store size
    program_length(LEN_MAX_CODE);
    send_request(MODE_READ, 10'd1023);
    send_request(MODE_FIND, '0);

    // single-bit map: fill it, then find has nothing and padding stays hidden
    program_length(11'd1);
    send_request(MODE_SET, '0);
    send_request(MODE_FIND, '0);
    send_request(MODE_READ, 10'd1);

    // random phases over several lengths
    run_phase(LEN_RESET, 90);

    // long receiver hold-off while requests keep coming
    sender_gaps     = 1'b0;
    hold_off_cycles = 250;
    repeat (10) random_op();
    sender_gaps = 1'b1;

    run_phase(11'd33, 70);
    run_phase(11'd17, 60);
    run_phase(11'd1, 30);
    run_phase('0, 20);
    run_phase(LEN_MAX_CODE, 40);
    run_phase(LEN_W'($urandom_range(2, 1023)), 70);
    run_phase(LEN_W'($urandom_range(TOTAL_BITS + 1, LEN_MAX_CODE)), 30);

    // closing stretch at full rate on both sides
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_phase(LEN_W'($urandom_range(32, 64)), 60);

    // wait for the last answers and a little extra
    drain();
    repeat (40) @(posedge clk);

    $display("covered %0d request words and %0d result words over %0d length settings",
             words_sent, bitmap_model.answered, lengths_tried);
    $display("nonzero free hits %0d, full-map misses %0d, range rejects %0d, cycles %0d",
             bitmap_model.free_hits, bitmap_model.full_misses,
             bitmap_model.range_rejects, cycle_count);
    if (bitmap_model.failures == 0 && bitmap_model.owed() == 0) begin
      $display("PASS allocation_bitmap_first_free_unit");
    end else begin
      $display("FAIL allocation_bitmap_first_free_unit");
    end
    $finish;
  end

endmodule
